// File: hw/rtl/lbpre_pkg.sv
`default_nettype none

package lbpre_pkg;

   localparam int LED_COUNT_DEF = 3;

   // stream widths
   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 1;

   // shared serial divider
   localparam int DIVIDEND_W = 17;
   localparam int DIVISOR_W  = 9;
   localparam int DIV_CNT_W  = 5;

   localparam logic [6:0]  MID_MAX    = 7'd127;
   localparam logic [15:0] DELAY_CAP  = 16'd7500;
   localparam logic [8:0]  HALF_SEC   = 9'd500;
   localparam logic [16:0] DWELL_CAP  = 17'd60;
   localparam logic [3:0]  NIBBLE_MAX = 4'hf;

   localparam logic [7:0] DELAY_KEEP_MASK = 8'h0f;
   localparam logic [7:0] DUTY_HIGH       = 8'hf0;
   localparam logic [7:0] SLOPE_BIT       = 8'h10;
   localparam logic [7:0] ON_BIT          = 8'h01;
   localparam logic [7:0] PULSE_DUTY      = 8'hff;

   // request kinds
   typedef enum logic [1:0] {
      CMD_OFF   = 2'd0,
      CMD_ON    = 2'd1,
      CMD_PULSE = 2'd2,
      CMD_SLOPE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [3:0] sat_nibble(input logic [DIVIDEND_W-1:0] q);
      if (q > DIVIDEND_W'(NIBBLE_MAX)) return NIBBLE_MAX;
      else return q[3:0];
   endfunction

   // round a step time up to 4 ms, cap at 60 ms, return in 4 ms units
   function automatic logic [3:0] dwell_nibble(input logic [DIVIDEND_W-1:0] q);
      logic [5:0] t;
      t = q[5:0] + 6'd3;
      if (q > DWELL_CAP) return NIBBLE_MAX;
      else return t[5:2];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lbpre_divider.sv
`default_nettype none

module lbpre_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lbpre_pkg::div_req_type div_req,
   output lbpre_pkg::div_rsp_type    div_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [lbpre_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [lbpre_pkg::DIVIDEND_W-1:0] work_ff, work_in;
   logic [lbpre_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [lbpre_pkg::DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [lbpre_pkg::DIVISOR_W:0]    trial;
   logic                             fits;

   // one quotient bit per cycle, dividend shifts out as quotient shifts in
   assign trial = {rem_ff, work_ff[lbpre_pkg::DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = lbpre_pkg::DIV_CNT_W'(lbpre_pkg::DIVIDEND_W);
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (fits) rem_in = lbpre_pkg::DIVISOR_W'(trial - {1'b0, divisor_ff});
         else rem_in = trial[lbpre_pkg::DIVISOR_W-1:0];
         work_in = {work_ff[lbpre_pkg::DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - lbpre_pkg::DIV_CNT_W'(1);
         if (cnt_ff == lbpre_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

endmodule

`default_nettype wire

// File: hw/rtl/led_blink_pattern_register_encoder.sv
`default_nettype none

// Encodes one LED light request into that LED's register image and returns the
// updated enable byte, the current byte and the LED's five slope bytes. Off,
// steady on, bad requests and out-of-range LED indexes skip the divider. Pulse
// runs two divisions and slope seven (start delay, four dwell steps, two totals)
// on one shared 17-step bit-serial divider. One item is worked at a time; a new
// item is taken while the previous result still waits in the output register.
module led_blink_pattern_register_encoder #(
   parameter int LED_COUNT = lbpre_pkg::LED_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rgb_level, mid_level, start_delay_ms, on_time_ms, off_time_ms,
   // rise_first_ms, rise_second_ms, fall_first_ms, fall_second_ms
   input  wire logic [lbpre_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd, led_index
   input  wire logic [lbpre_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // enable_byte, current_byte, period_byte, duty_byte, delay_byte,
   // rise_dwell_byte, fall_dwell_byte
   output logic [lbpre_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // bad_request
   output logic [lbpre_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [3:0] OP_DLY  = 4'd0;
   localparam logic [3:0] OP_D1   = 4'd1;
   localparam logic [3:0] OP_D2   = 4'd2;
   localparam logic [3:0] OP_D3   = 4'd3;
   localparam logic [3:0] OP_D4   = 4'd4;
   localparam logic [3:0] OP_T1   = 4'd5;
   localparam logic [3:0] OP_T2   = 4'd6;
   localparam logic [3:0] OP_PON  = 4'd7;
   localparam logic [3:0] OP_POFF = 4'd8;

   localparam int SLOTS = 5;

   // request payload
   logic [1:0]  cmd_ff, led_ff;
   logic [23:0] rgb_ff;
   logic [7:0]  mid_ff;
   logic [15:0] sdel_ff, ton_ff, toff_ff, r1_ff, r2_ff, f1_ff, f2_ff;

   logic [1:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;

   logic [3:0] dly_ff, d1_ff, d2_ff, d3_ff, d4_ff, ton_nib_ff, toff_nib_ff;

   logic [7:0] enable_ff;
   logic [7:0] img_ff [LED_COUNT][SLOTS];

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_bad_ff;
   logic [lbpre_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   lbpre_pkg::div_req_type div_req;
   lbpre_pkg::div_rsp_type div_rsp;

   logic        accept, led_ok, mid_bad, need_div, last_op, zero_div, out_free, commit;
   logic [6:0]  mid7, inv7;
   logic [10:0] prod_a, prod_b;
   logic [11:0] prod_sum;
   logic [7:0]  cur_row [SLOTS];
   logic [7:0]  new_row [SLOTS];
   logic [7:0]  new_en, on_mask, slp_mask, level, cc;
   logic        bad;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign led_ok     = 32'(led_ff) < LED_COUNT;
   assign mid_bad    = mid_ff > 8'(lbpre_pkg::MID_MAX);
   // decide from the incoming item, as the registered copy lands in the cycle after
   assign need_div   = (32'(req_tuser[3:2]) < LED_COUNT) &&
                       ((req_tuser[1:0] == lbpre_pkg::CMD_PULSE) ||
                        ((req_tuser[1:0] == lbpre_pkg::CMD_SLOPE) &&
                         (req_tdata[31:24] <= 8'(lbpre_pkg::MID_MAX))));
   assign last_op    = (op_ff == OP_T2) || (op_ff == OP_POFF);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser[1:0];
         led_ff  <= req_tuser[3:2];
         rgb_ff  <= req_tdata[23:0];
         mid_ff  <= req_tdata[31:24];
         sdel_ff <= req_tdata[47:32];
         ton_ff  <= req_tdata[63:48];
         toff_ff <= req_tdata[79:64];
         r1_ff   <= req_tdata[95:80];
         r2_ff   <= req_tdata[111:96];
         f1_ff   <= req_tdata[127:112];
         f2_ff   <= req_tdata[143:128];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = need_div ? S_START : S_DONE;
         end
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (div_rsp.done) begin
               if (last_op) state_in = S_DONE;
               else begin
                  state_in = S_START;
                  op_in    = op_ff + 4'd1;
               end
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // pick the first division from the incoming item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_DLY;
      end else if ((state_ff == S_DONE) && !out_free) begin
         state_ff <= state_in;
      end else if ((state_ff == S_IDLE) && accept) begin
         state_ff <= state_in;
         op_ff    <= (req_tuser[1:0] == lbpre_pkg::CMD_PULSE) ? OP_PON : OP_DLY;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // divider operands per step
   assign mid7     = mid_ff[6:0];
   assign inv7     = lbpre_pkg::MID_MAX - mid7;

   always_comb begin
      prod_a = 11'd0;
      prod_b = 11'd0;
      if (op_ff == OP_T2) begin
         prod_a = 11'(d4_ff) * 11'(mid7);
         prod_b = 11'(d3_ff) * 11'(inv7);
      end else begin
         prod_a = 11'(d1_ff) * 11'(mid7);
         prod_b = 11'(d2_ff) * 11'(inv7);
      end
   end

   assign prod_sum = 12'(prod_a) + 12'(prod_b);

   always_comb begin
      div_req.start    = (state_ff == S_START);
      div_req.dividend = '0;
      div_req.divisor  = lbpre_pkg::HALF_SEC;
      case (op_ff)
         OP_DLY: begin
            div_req.dividend = 17'((sdel_ff > lbpre_pkg::DELAY_CAP) ?
                                   lbpre_pkg::DELAY_CAP : sdel_ff);
         end
         OP_D1: begin
            div_req.dividend = 17'(r1_ff);
            div_req.divisor  = 9'(mid7);
         end
         OP_D2: begin
            div_req.dividend = 17'(r2_ff);
            div_req.divisor  = 9'(inv7);
         end
         OP_D3: begin
            div_req.dividend = 17'(f1_ff);
            div_req.divisor  = 9'(inv7);
         end
         OP_D4: begin
            div_req.dividend = 17'(f2_ff);
            div_req.divisor  = 9'(mid7);
         end
         OP_T1: begin
            div_req.dividend = 17'({prod_sum, 2'b00}) + 17'(ton_ff)
                               + 17'(lbpre_pkg::HALF_SEC - 9'd1);
         end
         OP_T2: begin
            div_req.dividend = 17'({prod_sum, 2'b00}) + 17'(toff_ff)
                               + 17'(lbpre_pkg::HALF_SEC - 9'd1);
         end
         OP_PON: begin
            div_req.dividend = 17'(ton_ff) + 17'(lbpre_pkg::HALF_SEC - 9'd1);
         end
         OP_POFF: begin
            div_req.dividend = 17'(toff_ff) + 17'(lbpre_pkg::HALF_SEC - 9'd1);
         end
         default: div_req.dividend = '0;
      endcase
   end

   assign zero_div = (div_req.divisor == '0);

   lbpre_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // a ramp with no brightness steps gets dwell zero
   always_ff @(posedge clock) begin
      if ((state_ff == S_WAIT) && div_rsp.done) begin
         case (op_ff)
            OP_DLY: dly_ff <= lbpre_pkg::sat_nibble(div_rsp.quotient);
            OP_D1:  d1_ff  <= zero_div ? 4'd0 : lbpre_pkg::dwell_nibble(div_rsp.quotient);
            OP_D2:  d2_ff  <= zero_div ? 4'd0 : lbpre_pkg::dwell_nibble(div_rsp.quotient);
            OP_D3:  d3_ff  <= zero_div ? 4'd0 : lbpre_pkg::dwell_nibble(div_rsp.quotient);
            OP_D4:  d4_ff  <= zero_div ? 4'd0 : lbpre_pkg::dwell_nibble(div_rsp.quotient);
            OP_T1, OP_PON:  ton_nib_ff  <= lbpre_pkg::sat_nibble(div_rsp.quotient);
            OP_T2, OP_POFF: toff_nib_ff <= lbpre_pkg::sat_nibble(div_rsp.quotient);
            default: dly_ff <= dly_ff;
         endcase
      end
   end

   // read the addressed LED's image
   always_comb begin
      for (int s = 0; s < SLOTS; s++) cur_row[s] = 8'd0;
      for (int l = 0; l < LED_COUNT; l++) begin
         if (led_ff == 2'(l)) begin
            for (int s = 0; s < SLOTS; s++) cur_row[s] = img_ff[l][s];
         end
      end
   end

   always_comb begin
      case (led_ff)
         2'd0:    level = rgb_ff[23:16];
         2'd1:    level = rgb_ff[15:8];
         2'd2:    level = rgb_ff[7:0];
         default: level = 8'd0;
      endcase
   end

   assign on_mask  = lbpre_pkg::ON_BIT << led_ff;
   assign slp_mask = lbpre_pkg::SLOPE_BIT << led_ff;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) new_row[s] = cur_row[s];
      new_en = enable_ff;
      cc     = 8'd0;
      bad    = 1'b0;
      case (cmd_ff)
         lbpre_pkg::CMD_OFF: begin
            new_en     = enable_ff & ~on_mask & ~slp_mask;
            new_row[2] = cur_row[2] & lbpre_pkg::DELAY_KEEP_MASK;
         end
         lbpre_pkg::CMD_ON: begin
            cc     = level;
            new_en = (enable_ff | on_mask) & ~slp_mask;
         end
         lbpre_pkg::CMD_PULSE: begin
            cc         = level;
            new_en     = enable_ff | on_mask | slp_mask;
            new_row[0] = {toff_nib_ff, ton_nib_ff};
            new_row[1] = lbpre_pkg::PULSE_DUTY;
            new_row[2] = 8'd0;
            new_row[3] = 8'd0;
            new_row[4] = 8'd0;
         end
         lbpre_pkg::CMD_SLOPE: begin
            if (mid_bad) begin
               bad = 1'b1;
            end else begin
               cc         = level;
               new_en     = enable_ff | on_mask | slp_mask;
               new_row[0] = {toff_nib_ff, ton_nib_ff};
               new_row[1] = lbpre_pkg::DUTY_HIGH | {4'd0, mid_ff[6:3]};
               new_row[2] = {dly_ff, 4'd0};
               new_row[3] = {d2_ff, d1_ff};
               new_row[4] = {d4_ff, d3_ff};
            end
         end
         default: bad = 1'b0;
      endcase
   end

   // commit the image for an in-range LED and load the result together
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 8'd0;
         for (int l = 0; l < LED_COUNT; l++) begin
            for (int s = 0; s < SLOTS; s++) img_ff[l][s] <= 8'd0;
         end
      end else if (commit && led_ok) begin
         enable_ff <= new_en;
         for (int l = 0; l < LED_COUNT; l++) begin
            if (led_ff == 2'(l)) begin
               for (int s = 0; s < SLOTS; s++) img_ff[l][s] <= new_row[s];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         if (led_ok) begin
            rsp_bad_ff  <= bad;
            rsp_data_ff <= {new_row[4], new_row[3], new_row[2], new_row[1], new_row[0],
                            cc, new_en};
         end else begin
            rsp_bad_ff  <= 1'b0;
            rsp_data_ff <= {48'd0, enable_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WAIT))
      else $error("divider finished outside of a wait step");

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed item produced no result");

   a_bad_no_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_data_ff[15:8] == 8'd0))
      else $error("rejected item carries a current setting");

   a_enable_unused_bits: assert property (@(posedge clock) disable iff (reset)
      !enable_ff[3] && !enable_ff[7])
      else $error("reserved enable bit set");

endmodule

`default_nettype wire
